@@ rtl/hid_report_message_framer_macros.svh @@
// Assertion macros shared by the report framer RTL.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef HID_REPORT_MESSAGE_FRAMER_MACROS_SVH
`define HID_REPORT_MESSAGE_FRAMER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define HRMF_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define HRMF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HRMF_ASSERT_NOW(name, ante, cons, msg)
`define HRMF_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

@@ rtl/hrmf_pkg.sv @@
// Types and constants shared by the report framer modules.
// Depends on nothing.
package hrmf_pkg;

    // Report geometry.
    localparam int REPORT_BYTES = 64;
    localparam int POS_W        = $clog2(REPORT_BYTES);
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_LAST    = pos_t'(REPORT_BYTES - 1);
    localparam pos_t HDR_CMD     = pos_t'(4);
    localparam pos_t HDR_LEN_HI  = pos_t'(5);
    localparam pos_t HDR_LEN_LO  = pos_t'(6);
    localparam pos_t CONT_SEQ    = pos_t'(4);
    localparam pos_t KA_CMD      = pos_t'(4);
    localparam pos_t KA_LEN_HI   = pos_t'(5);
    localparam pos_t KA_LEN_LO   = pos_t'(6);
    localparam pos_t KA_STATUS   = pos_t'(7);

    localparam logic [7:0] KEEPALIVE_CODE = 8'hBB;

    // Field widths of a request.
    localparam int CMD_W  = 2;
    localparam int CHAN_W = 32;
    localparam int LEN_W  = 13;
    localparam int SEQ_W  = 7;

    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_START = 2'd0;
    localparam cmd_t CMD_DATA  = 2'd1;
    localparam cmd_t CMD_KEEP  = 2'd2;

    // Classified operation kinds passed from front to back.
    typedef logic [1:0] op_kind_t;
    localparam op_kind_t OP_START  = 2'd0;
    localparam op_kind_t OP_DATA   = 2'd1;
    localparam op_kind_t OP_KEEP   = 2'd2;
    localparam op_kind_t OP_REJECT = 2'd3;

    // One queued operation. fin marks an empty message on a start and the
    // final payload byte on a data operation.
    typedef struct packed {
        op_kind_t          kind;
        logic              fin;
        logic [CHAN_W-1:0] channel;
        logic [7:0]        frame_command;
        logic [LEN_W-1:0]  message_length;
        logic [7:0]        data_byte;
    } op_t;

    // Operation queue between the two halves.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

@@ rtl/hrmf_front.sv @@
// Front half of the framer: accepts requests and classifies them.
// Depends on hrmf_pkg and the assertion macro header.
`include "hid_report_message_framer_macros.svh"

module hrmf_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hrmf_pkg::cmd_t        s_command,
    input  logic [31:0]           s_channel_id,
    input  logic [7:0]            s_frame_command,
    input  logic [12:0]           s_message_length,
    input  logic [7:0]            s_data_byte,
    input  logic                  q_full,
    output logic                  push,
    output hrmf_pkg::op_t         push_op
);
    import hrmf_pkg::*;

    logic             open_reg, open_next;
    logic [LEN_W-1:0] remaining_reg, remaining_next;

    // Requests are taken whenever the queue has room.
    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // Classify the request against the message state seen so far.
    always_comb begin
        push_op.kind           = OP_REJECT;
        push_op.fin            = 1'b0;
        push_op.channel        = s_channel_id;
        push_op.frame_command  = s_frame_command;
        push_op.message_length = s_message_length;
        push_op.data_byte      = s_data_byte;
        case (s_command)
            CMD_START: begin
                if (!open_reg) begin
                    push_op.kind = OP_START;
                    push_op.fin  = (s_message_length == '0);
                end
            end
            CMD_DATA: begin
                if (open_reg) begin
                    push_op.kind = OP_DATA;
                    push_op.fin  = (remaining_reg == LEN_W'(1));
                end
            end
            CMD_KEEP: begin
                if (!open_reg) begin
                    push_op.kind = OP_KEEP;
                end
            end
            default: begin
                push_op.kind = OP_REJECT;
            end
        endcase
    end

    // Track whether a message is open and how many payload bytes remain.
    always_comb begin
        open_next      = open_reg;
        remaining_next = remaining_reg;
        if (push) begin
            if (push_op.kind == OP_START && !push_op.fin) begin
                open_next      = 1'b1;
                remaining_next = s_message_length;
            end else if (push_op.kind == OP_DATA) begin
                remaining_next = remaining_reg - LEN_W'(1);
                if (push_op.fin) begin
                    open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= 1'b0;
            remaining_reg <= '0;
        end else begin
            open_reg      <= open_next;
            remaining_reg <= remaining_next;
        end
    end

    `HRMF_ASSERT_NOW(a_open_has_bytes, open_reg, remaining_reg != '0, "open message with no bytes left")

endmodule

@@ rtl/hrmf_queue.sv @@
// Short operation queue between the front and back halves.
// Depends on hrmf_pkg.
module hrmf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hrmf_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output hrmf_pkg::op_t head_op
);
    import hrmf_pkg::*;

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW:0] rd_ptr_reg, rd_ptr_next;

    // Pointers carry one extra bit to tell full from empty.
    assign head_valid = (wr_ptr_reg != rd_ptr_reg);
    assign full       = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW]) &&
                        (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);
    assign head_op    = entry_reg[rd_ptr_reg[QUEUE_AW-1:0]];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (QUEUE_AW+1)'(push);
        rd_ptr_next = rd_ptr_reg + (QUEUE_AW+1)'(pop);
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg[QUEUE_AW-1:0]] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

@@ rtl/hrmf_back.sv @@
// Back half of the framer: turns queued operations into report bytes.
// Depends on hrmf_pkg and the assertion macro header.
`include "hid_report_message_framer_macros.svh"

module hrmf_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  hrmf_pkg::op_t head_op,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_report_byte,
    output logic          m_last_of_report,
    output logic          m_last_of_message,
    output logic          m_last_of_run,
    output logic          m_rejected
);
    import hrmf_pkg::*;

    // Picks one byte of a channel id, most significant first.
    function automatic logic [7:0] chan_byte(input logic [CHAN_W-1:0] ch,
                                             input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = ch[31:24];
            2'd1:    b = ch[23:16];
            2'd2:    b = ch[15:8];
            default: b = ch[7:0];
        endcase
        return b;
    endfunction

    logic             busy_reg, busy_next;
    op_t              cur_reg, cur_next;
    pos_t             pos_reg, pos_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic             data_done_reg, data_done_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg;
    logic       lrep_reg, lmsg_reg, lrun_reg, rej_reg;

    op_t        op;
    logic       have, advance, fire, at_last;
    logic [7:0] byte_val;
    logic       op_end, lrep, lmsg, rej, data_now;

    // Current operation: the one in progress, else the queue head.
    always_comb begin
        op      = busy_reg ? cur_reg : head_op;
        have    = busy_reg || head_valid;
        advance = !m_valid_reg || m_ready;
        fire    = advance && have;
        at_last = (pos_reg == POS_LAST);
        pop     = fire && !busy_reg;
    end

    // Byte and flags for the current position of the current operation.
    always_comb begin
        byte_val = 8'h00;
        op_end   = 1'b0;
        lrep     = at_last;
        lmsg     = 1'b0;
        rej      = 1'b0;
        data_now = 1'b0;
        case (op.kind)
            OP_START: begin
                if (pos_reg < HDR_CMD) begin
                    byte_val = chan_byte(op.channel, pos_reg[1:0]);
                end else if (pos_reg == HDR_CMD) begin
                    byte_val = op.frame_command;
                end else if (pos_reg == HDR_LEN_HI) begin
                    byte_val = 8'(op.message_length >> 8);
                end else if (pos_reg == HDR_LEN_LO) begin
                    byte_val = op.message_length[7:0];
                end
                op_end = op.fin ? at_last : (pos_reg == HDR_LEN_LO);
                lmsg   = at_last && op.fin;
            end
            OP_DATA: begin
                if (pos_reg < CONT_SEQ) begin
                    byte_val = chan_byte(chan_reg, pos_reg[1:0]);
                end else if (pos_reg == CONT_SEQ) begin
                    byte_val = {1'b0, seq_reg};
                end else if (!data_done_reg) begin
                    data_now = 1'b1;
                    byte_val = op.data_byte;
                end
                op_end = (data_now && !op.fin) || (op.fin && at_last);
                lmsg   = at_last && op.fin;
            end
            OP_KEEP: begin
                if (pos_reg < KA_CMD) begin
                    byte_val = chan_byte(op.channel, pos_reg[1:0]);
                end else if (pos_reg == KA_CMD) begin
                    byte_val = KEEPALIVE_CODE;
                end else if (pos_reg == KA_LEN_HI) begin
                    byte_val = 8'h00;
                end else if (pos_reg == KA_LEN_LO) begin
                    byte_val = 8'h01;
                end else if (pos_reg == KA_STATUS) begin
                    byte_val = op.data_byte;
                end
                op_end = at_last;
                lmsg   = at_last;
            end
            default: begin
                rej    = 1'b1;
                op_end = 1'b1;
                lrep   = 1'b0;
            end
        endcase
    end

    // Sequencer state updates, one byte per fire.
    always_comb begin
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        seq_next       = seq_reg;
        chan_next      = chan_reg;
        data_done_next = data_done_reg;
        if (fire) begin
            if (!busy_reg && !op_end) begin
                busy_next = 1'b1;
                cur_next  = head_op;
            end else if (busy_reg && op_end) begin
                busy_next = 1'b0;
            end
            if (op.kind != OP_REJECT) begin
                pos_next = at_last ? '0 : pos_reg + pos_t'(1);
            end
            if (op.kind == OP_START) begin
                chan_next = op.channel;
                seq_next  = '0;
            end
            if (op.kind == OP_DATA && pos_reg == CONT_SEQ) begin
                seq_next = seq_reg + SEQ_W'(1);
            end
            if (op_end) begin
                data_done_next = 1'b0;
            end else if (data_now) begin
                data_done_next = 1'b1;
            end
        end
    end

    assign m_valid_next = advance ? have : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            seq_reg       <= '0;
            chan_reg      <= '0;
            data_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            seq_reg       <= seq_next;
            chan_reg      <= chan_next;
            data_done_reg <= data_done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Output register payload and the held operation need no reset.
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (fire) begin
            byte_reg <= byte_val;
            lrep_reg <= lrep;
            lmsg_reg <= lmsg;
            lrun_reg <= op_end;
            rej_reg  <= rej;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_report_byte     = byte_reg;
    assign m_last_of_report  = lrep_reg;
    assign m_last_of_message = lmsg_reg;
    assign m_last_of_run     = lrun_reg;
    assign m_rejected        = rej_reg;

    `HRMF_ASSERT_NOW(a_reject_single, m_valid_reg && rej_reg, lrun_reg && (byte_reg == 8'h00) && !lrep_reg, "reject result is not a lone zero byte")
    `HRMF_ASSERT_NOW(a_msg_ends_report, m_valid_reg && lmsg_reg, lrep_reg && lrun_reg, "message end not on report end")
    `HRMF_ASSERT_NOW(a_busy_not_reject, busy_reg, cur_reg.kind != OP_REJECT, "reject held across cycles")
    `HRMF_ASSERT_NOW(a_done_only_last, data_done_reg, busy_reg && cur_reg.kind == OP_DATA && cur_reg.fin, "padding outside a final data request")
    `HRMF_ASSERT_NEXT(a_report_wrap, fire && at_last && op.kind != OP_REJECT, pos_reg == '0, "position did not wrap at report end")

endmodule

@@ rtl/hid_report_message_framer.sv @@
// HID report message framer: turns start, payload and keepalive requests
// into a stream of 64-byte HID reports, one report byte per result. A
// start request yields the 7-byte initial header (plus zero padding to 64
// bytes for an empty message); a payload request yields one byte, preceded
// by a 5-byte continuation header when it opens a new report and followed
// by zero padding when it is the message's last byte; a keepalive yields a
// full 64-byte report; a misplaced request yields one rejected zero byte.
// Unless the output stalls, the output sequencer produces one byte per cycle
// and a payload byte in the middle of a report is accepted every cycle; a
// request has 1 to 64 result bytes. A 4-entry request queue lets the
// input keep accepting while a long header or padding run is being sent.
// Depends on hrmf_pkg, hrmf_front, hrmf_queue and hrmf_back.
module hid_report_message_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_channel_id,
    input  logic [7:0]  s_frame_command,
    input  logic [12:0] s_message_length,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_report_byte,
    output logic        m_last_of_report,
    output logic        m_last_of_message,
    output logic        m_last_of_run,
    output logic        m_rejected
);
    import hrmf_pkg::*;

    logic q_full, push, pop, head_valid;
    op_t  push_op, head_op;

    // Request classification.
    hrmf_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (cmd_t'(s_command)),
        .s_channel_id     (s_channel_id),
        .s_frame_command  (s_frame_command),
        .s_message_length (s_message_length),
        .s_data_byte      (s_data_byte),
        .q_full           (q_full),
        .push             (push),
        .push_op          (push_op)
    );

    // Decoupling queue.
    hrmf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    // Report byte sequencer and output register.
    hrmf_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_valid        (head_valid),
        .head_op           (head_op),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_byte     (m_report_byte),
        .m_last_of_report  (m_last_of_report),
        .m_last_of_message (m_last_of_message),
        .m_last_of_run     (m_last_of_run),
        .m_rejected        (m_rejected)
    );

endmodule

@@ tb/hid_report_message_framer_checker.sv @@
// Scoreboard for the HID report framer: watches the request and report sides, predicts
// every report byte from the accepted requests and compares the delivered ones.
// Depends on hrmf_pkg for the report size, command codes and keepalive code.
`timescale 1ns / 1ps

module hid_report_message_framer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_channel_id,
    input  logic [7:0]  s_frame_command,
    input  logic [12:0] s_message_length,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_report_byte,
    input  logic        m_last_of_report,
    input  logic        m_last_of_message,
    input  logic        m_last_of_run,
    input  logic        m_rejected,
    output int          fail_count,
    output int          pending_count,
    output int          checked_count
);
    import hrmf_pkg::*;

    localparam logic [6:0] REPORT_LEN = 7'(REPORT_BYTES);

    typedef struct packed {
        logic [7:0] report_byte;
        logic       last_of_report;
        logic       last_of_message;
        logic       last_of_run;
        logic       rejected;
    } report_beat_t;

    // Report bytes still owed by the block, oldest first.
    report_beat_t report_queue[$];
    // Bytes produced by the request currently being framed.
    report_beat_t run_beats[$];
    report_beat_t want_beat;

    // Shadow of the framer's message state.
    logic        msg_open;
    logic [31:0] open_channel;
    logic [12:0] bytes_left;
    logic [6:0]  byte_pos;
    logic [6:0]  seq_no;

    function automatic void push_beat(logic [7:0] value, logic lrep, logic lmsg);
        report_beat_t beat;
        beat = '{value, lrep, lmsg, 1'b0, 1'b0};
        run_beats.push_back(beat);
    endfunction

    // One byte at the current report position; the end-of-message flag only
    // holds on the final byte of a report.
    function automatic void emit_byte(logic [7:0] value, logic lmsg);
        logic lrep;
        lrep = (byte_pos == REPORT_LEN - 7'd1);
        push_beat(value, lrep, lrep & lmsg);
        byte_pos = byte_pos + 7'd1;
    endfunction

    function automatic void emit_channel(logic [31:0] chan);
        emit_byte(chan[31:24], 1'b0);
        emit_byte(chan[23:16], 1'b0);
        emit_byte(chan[15:8], 1'b0);
        emit_byte(chan[7:0], 1'b0);
    endfunction

    // Zero fill to the end of the report, which closes the message.
    function automatic void pad_and_close();
        while (byte_pos < REPORT_LEN) begin
            emit_byte(8'h00, 1'b1);
        end
        byte_pos   = 7'd0;
        msg_open   = 1'b0;
        bytes_left = 13'd0;
    endfunction

    // Works out every report byte that one accepted request produces.
    function automatic void frame_request(logic [1:0] cmd, logic [31:0] chan,
                                          logic [7:0] fcmd, logic [12:0] len,
                                          logic [7:0] data);
        report_beat_t tail;
        logic [7:0]   ka_hdr [0:7];
        run_beats.delete();
        if (cmd == CMD_START && !msg_open) begin
            open_channel = chan;
            seq_no       = 7'd0;
            byte_pos     = 7'd0;
            msg_open     = 1'b1;
            bytes_left   = len;
            emit_channel(chan);
            emit_byte(fcmd, 1'b0);
            emit_byte(8'(len >> 8), 1'b0);
            emit_byte(len[7:0], 1'b0);
            if (len == 13'd0) begin
                pad_and_close();
            end
        end else if (cmd == CMD_DATA && msg_open) begin
            // A payload byte that opens a new report brings its continuation header.
            if (byte_pos == 7'd0 || byte_pos >= REPORT_LEN) begin
                byte_pos = 7'd0;
                emit_channel(open_channel);
                emit_byte({1'b0, seq_no}, 1'b0);
                seq_no = seq_no + 7'd1;
            end
            bytes_left = bytes_left - 13'd1;
            emit_byte(data, bytes_left == 13'd0);
            if (bytes_left == 13'd0) begin
                pad_and_close();
            end else if (byte_pos >= REPORT_LEN) begin
                byte_pos = 7'd0;
            end
        end else if (cmd == CMD_KEEP && !msg_open) begin
            // Keepalive is a self-contained report and leaves the message state alone.
            ka_hdr[0] = chan[31:24];
            ka_hdr[1] = chan[23:16];
            ka_hdr[2] = chan[15:8];
            ka_hdr[3] = chan[7:0];
            ka_hdr[4] = KEEPALIVE_CODE;
            ka_hdr[5] = 8'h00;
            ka_hdr[6] = 8'h01;
            ka_hdr[7] = data;
            for (int i = 0; i < REPORT_BYTES; i++) begin
                push_beat((i < 8) ? ka_hdr[i] : 8'h00, i == REPORT_BYTES - 1,
                          i == REPORT_BYTES - 1);
            end
        end else begin
            tail = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
            run_beats.push_back(tail);
        end
        // Mark the last byte of this request's run.
        tail = run_beats.pop_back();
        tail.last_of_run = 1'b1;
        run_beats.push_back(tail);
        foreach (run_beats[k]) begin
            report_queue.push_back(run_beats[k]);
        end
    endfunction

    function automatic void compare_field(string field, logic [7:0] want_v,
                                          logic [7:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, want_v, got_v);
            fail_count++;
        end
    endfunction

    // New requests are framed before the delivered byte is matched, so a
    // byte can never overtake the request that caused it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            msg_open      = 1'b0;
            open_channel  = 32'd0;
            bytes_left    = 13'd0;
            byte_pos      = 7'd0;
            seq_no        = 7'd0;
            fail_count    = 0;
            checked_count = 0;
            report_queue.delete();
        end else begin
            if (s_valid && s_ready) begin
                frame_request(s_command, s_channel_id, s_frame_command,
                              s_message_length, s_data_byte);
            end
            if (m_valid && m_ready) begin
                if (report_queue.size() == 0) begin
                    $display("%0t: unexpected report byte, expected none, actual %0h",
                             $time, m_report_byte);
                    fail_count++;
                end else begin
                    want_beat = report_queue.pop_front();
                    compare_field("report_byte", want_beat.report_byte, m_report_byte);
                    compare_field("last_of_report", want_beat.last_of_report,
                                  m_last_of_report);
                    compare_field("last_of_message", want_beat.last_of_message,
                                  m_last_of_message);
                    compare_field("last_of_run", want_beat.last_of_run, m_last_of_run);
                    compare_field("rejected", want_beat.rejected, m_rejected);
                    checked_count++;
                end
            end
        end
        pending_count = report_queue.size();
    end

endmodule

@@ tb/hid_report_message_framer_tb.sv @@
// Top of the HID report framer testbench: clock, reset, request stimulus and
// output back-pressure. Depends on hrmf_pkg, hid_report_message_framer and hid_report_message_framer_checker.
`timescale 1ns / 1ps

module hid_report_message_framer_tb;
    import hrmf_pkg::*;

    localparam cmd_t CMD_ILLEGAL   = 2'd3;
    localparam int   LONG_HOLD     = 300;
    localparam int   RANDOM_ITEMS  = 260;
    localparam int   SETTLE_CYCLES = 100;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command        = 2'd0;
    logic [31:0] s_channel_id     = 32'd0;
    logic [7:0]  s_frame_command  = 8'd0;
    logic [12:0] s_message_length = 13'd0;
    logic [7:0]  s_data_byte      = 8'd0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [7:0]  m_report_byte;
    logic        m_last_of_report;
    logic        m_last_of_message;
    logic        m_last_of_run;
    logic        m_rejected;

    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   sent_count     = 0;
    int   messages_sent  = 0;
    int   keepalives     = 0;
    int   misplaced_sent = 0;
    int   hold_requests  = 0;
    int   random_start;
    logic no_gaps        = 1'b0;

    hid_report_message_framer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_channel_id      (s_channel_id),
        .s_frame_command   (s_frame_command),
        .s_message_length  (s_message_length),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_byte     (m_report_byte),
        .m_last_of_report  (m_last_of_report),
        .m_last_of_message (m_last_of_message),
        .m_last_of_run     (m_last_of_run),
        .m_rejected        (m_rejected)
    );

    hid_report_message_framer_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_channel_id      (s_channel_id),
        .s_frame_command   (s_frame_command),
        .s_message_length  (s_message_length),
        .s_data_byte       (s_data_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_report_byte     (m_report_byte),
        .m_last_of_report  (m_last_of_report),
        .m_last_of_message (m_last_of_message),
        .m_last_of_run     (m_last_of_run),
        .m_rejected        (m_rejected),
        .fail_count        (fail_count),
        .pending_count     (pending_count),
        .checked_count     (checked_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offers one request after a random gap and holds it until accepted.
    // Valid is left high afterwards; the next call or a pause lowers it.
    task automatic send_request(cmd_t cmd, logic [31:0] chan, logic [7:0] fcmd,
                                logic [12:0] len, logic [7:0] data);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_channel_id     <= chan;
        s_frame_command  <= fcmd;
        s_message_length <= len;
        s_data_byte      <= data;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Fields that a request does not use still carry random values.
    task automatic send_start(logic [31:0] chan, logic [7:0] fcmd, logic [12:0] len);
        send_request(CMD_START, chan, fcmd, len, 8'($urandom));
    endtask

    task automatic send_data(logic [7:0] data);
        send_request(CMD_DATA, $urandom, 8'($urandom), 13'($urandom_range(0, 7609)), data);
    endtask

    task automatic send_keepalive(logic [31:0] chan, logic [7:0] status);
        send_request(CMD_KEEP, chan, 8'($urandom), 13'($urandom_range(0, 7609)), status);
        keepalives++;
    endtask

    // A request that does not fit the current state and must be rejected.
    task automatic send_misplaced(logic msg_open);
        cmd_t cmd;
        if (msg_open) begin
            case ($urandom_range(0, 2))
                0: cmd = CMD_START;
                1: cmd = CMD_KEEP;
                default: cmd = CMD_ILLEGAL;
            endcase
        end else begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_DATA : CMD_ILLEGAL;
        end
        send_request(cmd, $urandom, 8'($urandom), 13'($urandom_range(0, 7609)),
                     8'($urandom));
        misplaced_sent++;
    endtask

    // A whole message with random payload and the odd stray request mixed in.
    task automatic send_message(logic [31:0] chan, logic [7:0] fcmd, logic [12:0] len);
        send_start(chan, fcmd, len);
        for (int i = 0; i < int'(len); i++) begin
            if ($urandom_range(0, 23) == 0) begin
                send_misplaced(1'b1);
            end
            send_data(8'($urandom));
        end
        messages_sent++;
    endtask

    // Holds the sender back until every predicted byte has been delivered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        @(posedge aclk);
    endtask

    // Mostly short messages, with lengths around the report boundaries now and then.
    function automatic logic [12:0] pick_length();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: return 13'd0;
                    1: return 13'd1;
                    2: return 13'd56;
                    3: return 13'd57;
                    4: return 13'd58;
                    default: return 13'($urandom_range(115, 117));
                endcase
            end
            9: return 13'($urandom_range(59, 200));
            default: return 13'($urandom_range(1, 24));
        endcase
    endfunction

    // Output side: a random stall before each byte, or one long hold when asked.
    initial begin
        int stall;
        int holds_done;
        holds_done = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                stall = LONG_HOLD;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Stimulus and verdict.
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: rejections while idle, keepalive extremes, empty and tiny messages.
        send_request(CMD_DATA, 32'hFFFF_FFFF, 8'hFF, 13'd7609, 8'hFF);
        send_request(CMD_ILLEGAL, 32'd0, 8'd0, 13'd0, 8'd0);
        misplaced_sent += 2;
        send_keepalive(32'hFFFF_FFFF, 8'd1);
        send_keepalive(32'd0, 8'd2);
        send_keepalive(32'hA5C3_0F96, 8'hFF);
        send_start(32'hFFFF_FFFF, 8'hFF, 13'd0);
        send_start(32'd0, 8'h00, 13'd0);
        send_start(32'h1234_5678, 8'h86, 13'd1);
        send_data(8'hFF);
        send_start(32'h8000_0001, 8'h83, 13'd2);
        send_request(CMD_START, $urandom, 8'($urandom), 13'd7609, 8'($urandom));
        send_request(CMD_KEEP, $urandom, 8'($urandom), 13'd0, 8'd1);
        send_request(CMD_ILLEGAL, 32'hFFFF_FFFF, 8'hFF, 13'd7609, 8'hFF);
        misplaced_sent += 3;
        send_data(8'h00);
        send_data(8'hA5);
        messages_sent += 4;
        wait_drained();

        // Long output hold while the sender keeps pushing, so the input backs up.
        no_gaps = 1'b1;
        hold_requests <= hold_requests + 1;
        send_message($urandom, 8'($urandom), 13'd150);
        no_gaps = 1'b0;
        wait_drained();

        // Random part: well-formed messages with keepalives and strays in between.
        random_start = sent_count;
        while (sent_count - random_start < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 2) == 0) begin
                send_keepalive($urandom, ($urandom_range(0, 3) == 0) ?
                               8'($urandom) : 8'($urandom_range(1, 2)));
            end
            if ($urandom_range(0, 5) == 0) begin
                send_misplaced(1'b0);
            end
            send_message($urandom, 8'($urandom), pick_length());
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
            end
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d requests: %0d messages, %0d keepalives, %0d misplaced.",
                 sent_count, messages_sent, keepalives, misplaced_sent);
        $display("Checked %0d report bytes, %0d mismatches.", checked_count, fail_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("Timeout with %0d report bytes outstanding.", pending_count);
        $display("Test completed with failures");
        $finish;
    end

endmodule
